// ----- rtl/ascii_length_prefix_deframer_defines.svh -----
// Assertion helpers for the deframer top level.
`ifndef ASCII_LENGTH_PREFIX_DEFRAMER_DEFINES_SVH
`define ASCII_LENGTH_PREFIX_DEFRAMER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define ALPD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define ALPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/alpd_pkg.sv -----
`default_nettype none
package alpd_pkg;

   localparam int LEN_BITS      = 27;
   localparam int PROD_BITS     = LEN_BITS + 4;
   localparam int HDR_LEN_BITS  = 4;
   localparam int BYTE_BITS     = 8;

   localparam logic [HDR_LEN_BITS-1:0] HDR_LEN_RESET = HDR_LEN_BITS'(2);
   localparam logic [HDR_LEN_BITS-1:0] HDR_LEN_MIN   = HDR_LEN_BITS'(1);
   localparam logic [HDR_LEN_BITS-1:0] HDR_LEN_MAX   = HDR_LEN_BITS'(8);

   localparam logic [BYTE_BITS-1:0] CHAR_ZERO = 8'h30;
   localparam logic [BYTE_BITS-1:0] CHAR_NINE = 8'h39;

   typedef logic [LEN_BITS-1:0]     len_type;
   typedef logic [HDR_LEN_BITS-1:0] hdr_len_type;
   typedef logic [BYTE_BITS-1:0]    byte_type;

   // One delivered word on the result side.
   typedef struct packed {
      byte_type out_byte;
      logic     frame_last;
      logic     empty_frame;
   } rsp_type;

   // What one processed byte produces.
   typedef struct packed {
      logic    valid;
      rsp_type data;
   } step_res_type;

endpackage
`default_nettype wire

// ----- rtl/alpd_in_stage.sv -----
`default_nettype none
module alpd_in_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire alpd_pkg::byte_type req_in_byte,
   input  wire logic              step_fire,
   output logic                   in_valid,
   output alpd_pkg::byte_type     in_byte
);
   import alpd_pkg::*;

   logic     valid_ff, valid_in;
   byte_type byte_ff,  byte_in;
   logic     take;

   // Free when empty or when the held word is consumed this cycle.
   assign req_ready = !valid_ff || step_fire;
   assign take      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (take) begin
         valid_in = 1'b1;
         byte_in  = req_in_byte;
      end else if (step_fire) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign in_valid = valid_ff;
   assign in_byte  = byte_ff;

endmodule
`default_nettype wire

// ----- rtl/alpd_deframe.sv -----
`default_nettype none
module alpd_deframe (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wr_en,
   input  wire alpd_pkg::hdr_len_type csr_wr_data,
   input  wire logic                  step_fire,
   input  wire alpd_pkg::byte_type    in_byte,
   output alpd_pkg::step_res_type     step_res
);
   import alpd_pkg::*;

   hdr_len_type header_len_ff;
   logic        in_payload_ff,     in_payload_in;
   hdr_len_type digits_seen_ff,    digits_seen_in;
   logic        number_stopped_ff, number_stopped_in;
   len_type     header_value_ff,   header_value_in;
   len_type     bytes_left_ff,     bytes_left_in;

   hdr_len_type              eff_len;
   logic                     is_digit;
   logic [3:0]               digit_diff;
   logic [PROD_BITS-1:0]     prod;
   len_type                  value_next;
   len_type                  left_dec;

   // Clamp the programmed length into 1..8.
   always_comb begin
      if (header_len_ff == '0) begin
         eff_len = HDR_LEN_MIN;
      end else if (header_len_ff > HDR_LEN_MAX) begin
         eff_len = HDR_LEN_MAX;
      end else begin
         eff_len = header_len_ff;
      end
   end

   assign is_digit   = in_byte inside {[CHAR_ZERO:CHAR_NINE]};
   // an ASCII digit carries its value in the low nibble
   assign digit_diff = in_byte[3:0];
   // value * 10 + digit as two shifts and two adds
   assign prod = {header_value_ff, 3'b000} + {2'b00, header_value_ff, 1'b0}
               + {{(PROD_BITS-4){1'b0}}, digit_diff};
   assign left_dec = (bytes_left_ff != '0) ? bytes_left_ff - LEN_BITS'(1) : '0;

   always_comb begin
      in_payload_in     = in_payload_ff;
      digits_seen_in    = digits_seen_ff;
      number_stopped_in = number_stopped_ff;
      header_value_in   = header_value_ff;
      bytes_left_in     = bytes_left_ff;
      value_next        = header_value_ff;
      step_res          = '0;

      if (in_payload_ff) begin
         bytes_left_in            = left_dec;
         step_res.valid           = 1'b1;
         step_res.data.out_byte   = in_byte;
         step_res.data.frame_last = (left_dec == '0);
         if (left_dec == '0) begin
            in_payload_in = 1'b0;
         end
      end else begin
         if (!number_stopped_ff && is_digit) begin
            // saturate at all ones
            if (prod[PROD_BITS-1:LEN_BITS] != '0) begin
               value_next = '1;
            end else begin
               value_next = prod[LEN_BITS-1:0];
            end
         end else begin
            number_stopped_in = 1'b1;
         end
         header_value_in = value_next;
         digits_seen_in  = digits_seen_ff + HDR_LEN_BITS'(1);

         if (digits_seen_in >= eff_len) begin
            digits_seen_in    = '0;
            number_stopped_in = 1'b0;
            header_value_in   = '0;
            if (value_next == '0) begin
               step_res.valid            = 1'b1;
               step_res.data.frame_last  = 1'b1;
               step_res.data.empty_frame = 1'b1;
            end else begin
               bytes_left_in = value_next;
               in_payload_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_len_ff <= HDR_LEN_RESET;
      end else if (csr_wr_en) begin
         header_len_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_payload_ff     <= 1'b0;
         digits_seen_ff    <= '0;
         number_stopped_ff <= 1'b0;
         header_value_ff   <= '0;
         bytes_left_ff     <= '0;
      end else if (step_fire) begin
         in_payload_ff     <= in_payload_in;
         digits_seen_ff    <= digits_seen_in;
         number_stopped_ff <= number_stopped_in;
         header_value_ff   <= header_value_in;
         bytes_left_ff     <= bytes_left_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/alpd_out_stage.sv -----
`default_nettype none
module alpd_out_stage (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step_fire,
   input  wire alpd_pkg::step_res_type step_res,
   output logic                        out_free,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output alpd_pkg::rsp_type           rsp_data
);
   import alpd_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff,  data_in;
   logic    load;

   assign out_free = !valid_ff || rsp_ready;
   assign load     = step_fire && step_res.valid;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = step_res.data;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule
`default_nettype wire

// ----- rtl/ascii_length_prefix_deframer.sv -----
// Length-prefixed stream deframer with an ASCII decimal length header.
// req_*: one stream byte per word, valid/ready. Each frame is a header of
//   header_len bytes (decimal digits, the first non-digit ends the number)
//   followed by that many payload bytes.
// rsp_*: one payload byte per word; rsp_frame_last marks the frame's final
//   byte. A header of value zero yields a single word with rsp_empty_frame
//   and rsp_frame_last set and rsp_out_byte zero. Header bytes yield nothing.
// csr_*: write header_len (low 4 bits; 0 acts as 1, above 8 acts as 8).
//   Write only while idle; it applies from the next header byte on.
// Throughput: one byte per cycle while rsp_ready is high; the input
//   register, the single-pass header/payload logic and the result register
//   each pass one word a cycle, in that order from req_* to rsp_*.
// Stall: while rsp_ready is low with a word pending, the input register
//   holds one more byte, then req_ready drops until the result is taken.
// Reset: synchronous; clears both stages, returns to header parsing and
//   sets header_len to 2. Header values saturate at 2^27 - 1.
`default_nettype none
`include "ascii_length_prefix_deframer_defines.svh"
module ascii_length_prefix_deframer (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire alpd_pkg::byte_type    req_in_byte,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output alpd_pkg::byte_type         rsp_out_byte,
   output logic                       rsp_frame_last,
   output logic                       rsp_empty_frame,
   input  wire logic                  csr_wr_en,
   input  wire alpd_pkg::hdr_len_type csr_wr_data
);
   import alpd_pkg::*;

   logic         in_valid;
   byte_type     in_byte;
   logic         out_free;
   logic         step_fire;
   step_res_type step_res;
   rsp_type      rsp_data;

   // Process the held byte whenever the result register can take a word.
   assign step_fire = in_valid && out_free;

   alpd_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .step_fire   (step_fire),
      .in_valid    (in_valid),
      .in_byte     (in_byte)
   );

   alpd_deframe u_deframe (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .step_fire   (step_fire),
      .in_byte     (in_byte),
      .step_res    (step_res)
   );

   alpd_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .step_fire (step_fire),
      .step_res  (step_res),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_out_byte    = rsp_data.out_byte;
   assign rsp_frame_last  = rsp_data.frame_last;
   assign rsp_empty_frame = rsp_data.empty_frame;

   // Empty marker always closes the frame and carries a zero byte.
   `ALPD_ASSERT_SAME(a_empty_marker, clock, reset, rsp_valid && rsp_empty_frame, rsp_frame_last && (rsp_out_byte == '0), "empty marker malformed")
   // A pending, stalled result is never overwritten by a new step.
   `ALPD_ASSERT_SAME(a_no_overwrite, clock, reset, rsp_valid && !rsp_ready, !step_fire, "result overwritten while stalled")
   // A step that produces a word always shows it on the next cycle.
   `ALPD_ASSERT_NEXT(a_result_lands, clock, reset, step_fire && step_res.valid, rsp_valid, "produced word lost")

endmodule
`default_nettype wire

// ----- verif/tb_ascii_length_prefix_deframer.sv -----
`timescale 1ns / 1ps
module tb_ascii_length_prefix_deframer;
   import alpd_pkg::*;

   // Random part length, split into phases that each run under one header_len.
   localparam int RANDOM_BYTES  = 1750;
   localparam int NUM_PHASES    = 10;
   // Cycles to let pass once nothing is awaited: one word may still sit in
   // the input register or the header logic.
   localparam int SETTLE_CYCLES = 6;
   localparam int CYCLE_LIMIT   = 250000;
   localparam len_type VALUE_MAX = '1;

   typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_type;

   // One line of the directed stimulus: a stream byte or a header_len write.
   // Where typed is set, word is the result that byte must give.
   typedef struct {
      row_kind_type kind;
      byte_type     data;
      bit           typed;
      rsp_type      word;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   byte_type    req_in_byte = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   byte_type    rsp_out_byte;
   logic        rsp_frame_last;
   logic        rsp_empty_frame;
   logic        csr_wr_en = 1'b0;
   hdr_len_type csr_wr_data = '0;

   // Free-running clock, 2 ns period.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   ascii_length_prefix_deframer dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_byte     (req_in_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_frame_last  (rsp_frame_last),
      .rsp_empty_frame (rsp_empty_frame),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   // ------------------------------------------------------------------
   // Deframer state as the testbench tracks it, starting from reset.
   // ------------------------------------------------------------------
   hdr_len_type cur_hdr_len  = HDR_LEN_RESET;
   bit          in_body      = 1'b0;
   logic [3:0]  hdr_count    = '0;
   bit          number_done  = 1'b0;
   len_type     hdr_value    = '0;
   len_type     body_left    = '0;

   rsp_type      awaited_words[$];
   stim_row_type directed_rows[$];
   int unsigned bytes_sent   = 0;
   int unsigned mismatches   = 0;
   int unsigned cycle_count  = 0;
   // Set for one whole phase: no idling on either side.
   bit          steady       = 1'b0;

   // Header bytes that count: 0 reads as 1, anything above 8 as 8.
   function automatic int unsigned eff_len();
      if (cur_hdr_len == '0) return HDR_LEN_MIN;
      if (cur_hdr_len > HDR_LEN_MAX) return HDR_LEN_MAX;
      return cur_hdr_len;
   endfunction

   // Advance the tracked state by one stream byte; returns 1 and the word
   // when the byte yields a result.
   function automatic bit deframe_byte(input byte_type b, output rsp_type w);
      longint unsigned acc;
      len_type         n;
      w = '0;
      if (in_body) begin
         if (body_left != '0) body_left = body_left - 1'b1;
         w.out_byte   = b;
         w.frame_last = (body_left == '0);
         if (body_left == '0) in_body = 1'b0;
         return 1'b1;
      end
      // Digits accumulate until the first non-digit; later bytes only count.
      if (!number_done && b >= CHAR_ZERO && b <= CHAR_NINE) begin
         acc = longint'(hdr_value) * 10 + longint'(b - CHAR_ZERO);
         hdr_value = (acc > longint'(VALUE_MAX)) ? VALUE_MAX : len_type'(acc);
      end else begin
         number_done = 1'b1;
      end
      hdr_count = hdr_count + 1'b1;
      if (hdr_count >= eff_len()) begin
         n           = hdr_value;
         hdr_count   = '0;
         number_done = 1'b0;
         hdr_value   = '0;
         if (n == '0) begin
            w.frame_last  = 1'b1;
            w.empty_frame = 1'b1;
            return 1'b1;
         end
         body_left = n;
         in_body   = 1'b1;
      end
      return 1'b0;
   endfunction

   // Any byte outside '0'..'9', with signs and space now and then.
   function automatic byte_type nondigit();
      byte_type c;
      case ($urandom_range(5))
         0: return "+";
         1: return "-";
         2: return " ";
         default: ;
      endcase
      do c = byte_type'($urandom_range(255)); while (c >= CHAR_ZERO && c <= CHAR_NINE);
      return c;
   endfunction

   function automatic stim_row_type b_row(input byte_type d);
      b_row = '{ROW_BYTE, d, 1'b0, '0};
   endfunction

   function automatic stim_row_type x_row(input byte_type d, input byte_type ob,
                                          input bit last, input bit empty);
      rsp_type w;
      w.out_byte    = ob;
      w.frame_last  = last;
      w.empty_frame = empty;
      x_row = '{ROW_BYTE, d, 1'b1, w};
   endfunction

   function automatic stim_row_type c_row(input hdr_len_type v);
      c_row = '{ROW_CFG, byte_type'(v), 1'b0, '0};
   endfunction

   // Drain: drop valid, wait out every awaited word, then let the last
   // header byte (which gives no word) clear the pipeline.
   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (awaited_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write header_len while the block is idle; it applies from the next byte.
   task automatic write_header_len(input hdr_len_type v);
      wait_quiet();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cur_hdr_len = v;
   endtask

   // Offer one stream byte and hold it until accepted. Valid is only
   // lowered for an idle cycle, so it never drops and rises in one step.
   task automatic send_byte(input byte_type b, input bit typed = 1'b0,
                            input rsp_type typed_word = '0);
      rsp_type w;
      bit      got;
      got = deframe_byte(b, w);
      if (typed) awaited_words.push_back(typed_word);
      else if (got) awaited_words.push_back(w);
      while (!steady && $urandom_range(99) < 33) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
   endtask

   // One frame with random content: mostly a well-formed header and its
   // payload, sometimes a header that a stop byte ends early or at once.
   task automatic send_frame();
      byte_type    hdr[$];
      int unsigned v;
      int unsigned rest;
      int unsigned eff;
      // Close a header left open across a register write; a stop byte keeps
      // its value as small as the digits already taken.
      while (!in_body && hdr_count != '0) send_byte(nondigit());
      while (in_body) send_byte(byte_type'($urandom_range(255)));
      eff = eff_len();
      if ($urandom_range(99) < 12) begin
         // Leading non-digit: the header reads as zero.
         hdr.push_back(nondigit());
         while (hdr.size() < eff) hdr.push_back(byte_type'($urandom_range(255)));
      end else begin
         case ($urandom_range(19))
            0, 1, 2: v = 0;
            3:       v = $urandom_range(300, 61);
            4, 5, 6: v = $urandom_range(60, 13);
            default: v = $urandom_range(12, 1);
         endcase
         if (eff == 1) v = v % 10;
         else if (eff == 2) v = v % 100;
         rest = v;
         do begin
            hdr.push_front(CHAR_ZERO + byte_type'(rest % 10));
            rest = rest / 10;
         end while (rest != 0);
         if ($urandom_range(1) == 0) begin
            // Zero-pad to the full header width.
            while (hdr.size() < eff) hdr.push_front(CHAR_ZERO);
         end else if (hdr.size() < eff) begin
            // Stop byte, then junk that no longer counts as digits.
            hdr.push_back(nondigit());
            while (hdr.size() < eff) hdr.push_back(byte_type'($urandom_range(255)));
         end
      end
      foreach (hdr[i]) begin
         send_byte(hdr[i]);
         if (hdr_count == '0) break;
      end
      while (in_body) send_byte(byte_type'($urandom_range(255)));
   endtask

   // ------------------------------------------------------------------
   // Result side: stall at random, check each accepted word in order.
   // Inputs are sampled at the edge, before this step's updates land.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : check_words
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_words.size() == 0) begin
            $error("unexpected word: out_byte %0h frame_last %0b empty_frame %0b",
                   rsp_out_byte, rsp_frame_last, rsp_empty_frame);
            mismatches++;
         end else begin
            want = awaited_words.pop_front();
            if (rsp_out_byte !== want.out_byte) begin
               $error("out_byte: expected %0h, got %0h", want.out_byte, rsp_out_byte);
               mismatches++;
            end
            if (rsp_frame_last !== want.frame_last) begin
               $error("frame_last: expected %0b, got %0b", want.frame_last, rsp_frame_last);
               mismatches++;
            end
            if (rsp_empty_frame !== want.empty_frame) begin
               $error("empty_frame: expected %0b, got %0b",
                      want.empty_frame, rsp_empty_frame);
               mismatches++;
            end
         end
      end
      rsp_ready <= steady ? 1'b1 : ($urandom_range(99) >= 33);
   end

   // Watchdog: give up on a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_ascii_length_prefix_deframer failed");
         $finish;
      end
   end

   initial begin
      int unsigned random_base;
      int unsigned phase_end;
      hdr_len_type setting;

      // Directed rows, header_len 2 after reset unless a write says otherwise.
      directed_rows = '{
         // "00": zero header gives the empty marker on its last byte
         b_row("0"), x_row("0", 8'h00, 1'b1, 1'b1),
         // "03" then three bytes, byte extremes among them
         b_row("0"), b_row("3"),
         x_row(8'h00, 8'h00, 1'b0, 1'b0),
         x_row(8'hFF, 8'hFF, 1'b0, 1'b0),
         x_row(8'h41, 8'h41, 1'b1, 1'b0),
         // a sign is just a non-digit: the header reads as zero
         b_row("-"), x_row("5", 8'h00, 1'b1, 1'b1),
         // "1 ": a space ends the number after one digit
         b_row("1"), b_row(" "), x_row(8'h80, 8'h80, 1'b1, 1'b0),
         // header_len 0 acts as 1
         c_row(4'd0), b_row("1"), x_row(8'h7F, 8'h7F, 1'b1, 1'b0),
         x_row("x", 8'h00, 1'b1, 1'b1),
         // header_len 15 acts as 8; shorten it mid-header and the next byte
         // ends the header
         c_row(4'd15), b_row("0"), b_row("0"), c_row(4'd1), b_row("1"),
         x_row(8'h55, 8'h55, 1'b1, 1'b0),
         // back to the reset width, then a few rows for the predictor alone
         c_row(HDR_LEN_RESET), b_row("2"), b_row("9"),
         b_row(8'h39), b_row(8'h30)
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         case (directed_rows[i].kind)
            ROW_CFG:  write_header_len(hdr_len_type'(directed_rows[i].data));
            ROW_BYTE: send_byte(directed_rows[i].data, directed_rows[i].typed,
                                directed_rows[i].word);
            default:  ;
         endcase
      end

      // Random phases: extremes of header_len first, then random settings.
      random_base = bytes_sent;
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0:       setting = HDR_LEN_MAX;
            1:       setting = HDR_LEN_MIN;
            2:       setting = '1;
            3:       setting = '0;
            default: setting = hdr_len_type'($urandom_range(15));
         endcase
         write_header_len(setting);
         steady = (p == 4);
         phase_end = random_base + (p + 1) * RANDOM_BYTES / NUM_PHASES;
         while (bytes_sent < phase_end) send_frame();
         // Leave a header half read now and then, so the next write lands
         // mid-header.
         if ($urandom_range(2) == 0) repeat ($urandom_range(3, 1)) send_byte(CHAR_ZERO);
      end

      // Drain everything still awaited, then let the pipeline settle.
      req_valid <= 1'b0;
      while (awaited_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("tb_ascii_length_prefix_deframer passed");
      end else begin
         $display("tb_ascii_length_prefix_deframer failed");
      end
      $finish;
   end

endmodule
